FILE: rtl/ttce_pkg.sv
// Shared types and constants for the text terminal cursor engine.
package ttce_pkg;

  localparam int unsigned DefColumns    = 80;
  localparam int unsigned DefRows       = 18;
  localparam int unsigned DefLeftOffset = 0;
  localparam int unsigned DefTopOffset  = 1;

  localparam logic [7:0] TextStyleReset   = 8'd3;
  localparam logic [7:0] CursorStyleReset = 8'd11;

  localparam logic [7:0] ChrTab   = 8'd9;
  localparam logic [7:0] ChrLf    = 8'd10;
  localparam logic [7:0] ChrCr    = 8'd13;
  localparam logic [7:0] ChrSpace = 8'd32;

  localparam logic       ReqPut   = 1'b0;
  localparam logic       ReqClear = 1'b1;

  localparam logic       CfgTextStyle   = 1'b0;
  localparam logic       CfgCursorStyle = 1'b1;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SCROLL = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CLEAR,
    PH_ERASE,
    PH_GLYPH,
    PH_TAB,
    PH_SCROLL,
    PH_DRAW
  } phase_e;

endpackage

FILE: rtl/text_terminal_cursor_engine_core.sv
// Text terminal cursor engine: turns characters into display cell actions.
//
// Input channel (s_axis): one beat per request. tuser selects put character
// or clear region; tdata carries the character byte.
// Output channel (m_axis): display actions, one per beat. tuser is the
// action kind, tlast marks the final action of a request.
// Config channel (cfg_*): writes text_style (index 0) or cursor_style
// (index 1); always ready, write only while the engine is idle.
// A request yields 1 (clear) to 6 (tab) actions, issued in order by the
// action sequencer whenever the output register is free; the
// next request is taken in the cycle its predecessor's last action is
// issued. The accepted request is registered into the phase and character
// registers, and each action is then registered into the output register.
// Output is a single register; a stalled receiver holds it and the
// sequencer waits, no action is dropped.
// Reset homes the cursor, sets both fill attributes and text_style to 3
// and cursor_style to 11; a clear homes the cursor, fills to text_style.
module text_terminal_cursor_engine_core
  import ttce_pkg::*;
#(
  parameter int unsigned COLUMNS     = DefColumns,
  parameter int unsigned ROWS        = DefRows,
  parameter int unsigned LEFT_OFFSET = DefLeftOffset,
  parameter int unsigned TOP_OFFSET  = DefTopOffset
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] screen_x, [13:8] screen_y,
                                      // [21:14] glyph, [29:22] attribute
  output logic [1:0]  m_axis_tuser,   // [1:0] action
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam logic [8:0] ColCount = 9'(COLUMNS);
  localparam logic [7:0] ColLast  = 8'(COLUMNS - 1);
  localparam logic [6:0] RowCount = 7'(ROWS);
  localparam logic [5:0] RowLast  = 6'(ROWS - 1);
  localparam logic [7:0] LeftOff  = 8'(LEFT_OFFSET);
  localparam logic [5:0] TopOff   = 6'(TOP_OFFSET);

  logic [7:0] text_style_q, cursor_style_q;
  logic [7:0] col_q, col_d;
  logic [5:0] row_q, row_d;
  logic [7:0] row_fill_q, row_fill_d;
  logic [7:0] below_fill_q, below_fill_d;
  logic [7:0] tab_stop_q, tab_stop_d;
  phase_e     phase_q, phase_d;
  logic [7:0] char_q;

  logic       out_valid_q;
  action_e    out_action_q, beat_action;
  logic [7:0] out_x_q, beat_x;
  logic [5:0] out_y_q, beat_y;
  logic [7:0] out_glyph_q, beat_glyph;
  logic [7:0] out_attr_q, beat_attr;
  logic       out_last_q, beat_last;

  logic       out_free, issue, in_accept;
  logic       newline;
  logic [8:0] col_inc, tab_raw;
  logic [7:0] tab_stop;
  logic       wrap_scroll;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_style_q   <= TextStyleReset;
      cursor_style_q <= CursorStyleReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgTextStyle) text_style_q <= cfg_data_i;
      else                             cursor_style_q <= cfg_data_i;
    end
  end

  assign out_free  = !out_valid_q || m_axis_tready;
  assign issue     = (phase_q != PH_IDLE) && out_free;
  assign s_axis_tready = (phase_q == PH_IDLE) ||
                         (issue && (phase_q == PH_DRAW || phase_q == PH_CLEAR));
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign newline     = (char_q == ChrLf) || (char_q == ChrCr);
  assign col_inc     = {1'b0, col_q} + 9'd1;
  assign tab_raw     = ({1'b0, col_q} + 9'd4) & ~9'd3;
  assign tab_stop    = (tab_raw >= ColCount) ? ColLast : tab_raw[7:0];
  assign wrap_scroll = ({1'b0, row_q} + 7'd1) >= RowCount;

  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    row_fill_d   = row_fill_q;
    below_fill_d = below_fill_q;
    tab_stop_d   = tab_stop_q;
    phase_d      = phase_q;
    beat_action  = ACT_WRITE;
    beat_x       = LeftOff + col_q;
    beat_y       = TopOff + row_q;
    beat_glyph   = ChrSpace;
    beat_attr    = text_style_q;
    beat_last    = 1'b0;

    case (phase_q)
      PH_CLEAR: begin
        beat_action  = ACT_CLEAR;
        beat_x       = '0;
        beat_y       = '0;
        beat_last    = 1'b1;
        col_d        = '0;
        row_d        = '0;
        row_fill_d   = text_style_q;
        below_fill_d = text_style_q;
        phase_d      = PH_IDLE;
      end
      PH_ERASE: begin
        beat_attr = row_fill_q;
        if (newline) begin
          col_d = '0;
          if (wrap_scroll) begin
            phase_d = PH_SCROLL;
          end else begin
            row_d      = row_q + 6'd1;
            row_fill_d = below_fill_q;
            phase_d    = PH_DRAW;
          end
        end else if (char_q == ChrTab) begin
          tab_stop_d = tab_stop;
          phase_d    = (tab_stop > col_q) ? PH_TAB : PH_DRAW;
        end else begin
          phase_d = PH_GLYPH;
        end
      end
      PH_GLYPH: begin
        beat_glyph = char_q;
        if (col_inc >= ColCount) begin
          // wrap to the next row
          col_d = '0;
          if (wrap_scroll) begin
            phase_d = PH_SCROLL;
          end else begin
            row_d      = row_q + 6'd1;
            row_fill_d = below_fill_q;
            phase_d    = PH_DRAW;
          end
        end else begin
          col_d   = col_inc[7:0];
          phase_d = PH_DRAW;
        end
      end
      PH_TAB: begin
        // cursor column walks over the blanks and ends on the tab stop
        col_d = col_inc[7:0];
        if (col_inc[7:0] == tab_stop_q) phase_d = PH_DRAW;
      end
      PH_SCROLL: begin
        beat_action = ACT_SCROLL;
        beat_x      = '0;
        beat_y      = '0;
        row_d       = RowLast;
        row_fill_d  = text_style_q;
        phase_d     = PH_DRAW;
      end
      PH_DRAW: begin
        beat_attr = cursor_style_q;
        beat_last = 1'b1;
        phase_d   = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (in_accept) phase_d = (s_axis_tuser == ReqClear) ? PH_CLEAR : PH_ERASE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      col_q        <= '0;
      row_q        <= '0;
      row_fill_q   <= TextStyleReset;
      below_fill_q <= TextStyleReset;
      tab_stop_q   <= '0;
    end else begin
      if (issue) begin
        col_q        <= col_d;
        row_q        <= row_d;
        row_fill_q   <= row_fill_d;
        below_fill_q <= below_fill_d;
        tab_stop_q   <= tab_stop_d;
      end
      if (issue || in_accept) phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) char_q <= s_axis_tdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_action_q <= beat_action;
      out_x_q      <= beat_x;
      out_y_q      <= beat_y;
      out_glyph_q  <= beat_glyph;
      out_attr_q   <= beat_attr;
      out_last_q   <= beat_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_attr_q, out_glyph_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_action_q;
  assign m_axis_tlast  = out_last_q;

endmodule
